// File: rtl/core/sctc_pkg.sv
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types and constants of the set-1 scancode to character decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sctc_pkg;

  localparam int unsigned FIFO_DEPTH     = 256;
  localparam int unsigned FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int unsigned DEAD_KEY_SLOTS = 8;
  localparam int unsigned SLOT_W         = (DEAD_KEY_SLOTS > 1) ? $clog2(DEAD_KEY_SLOTS) : 1;
  localparam int unsigned CMP_DEPTH      = DEAD_KEY_SLOTS * 256;
  localparam int unsigned CMP_AW         = $clog2(CMP_DEPTH);
  localparam int unsigned MAP_DEPTH      = 128;
  localparam int unsigned MAP_AW         = 7;

  localparam logic [2:0] REQ_SCAN    = 3'd0;
  localparam logic [2:0] REQ_POP     = 3'd1;
  localparam logic [2:0] REQ_CLEAR   = 3'd2;
  localparam logic [2:0] REQ_KEYMAP  = 3'd3;
  localparam logic [2:0] REQ_COMPOSE = 3'd4;

  localparam logic [1:0] MAP_NORMAL = 2'd0;
  localparam logic [1:0] MAP_SHIFT  = 2'd1;
  localparam logic [1:0] MAP_ALTGR  = 2'd2;

  localparam logic CFG_DEAD_FIRST = 1'b0;
  localparam logic CFG_DEAD_LAST  = 1'b1;

  localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_UP        = 8'h48;
  localparam logic [7:0] SC_PGUP      = 8'h49;
  localparam logic [7:0] SC_LEFT      = 8'h4B;
  localparam logic [7:0] SC_RIGHT     = 8'h4D;
  localparam logic [7:0] SC_DOWN      = 8'h50;
  localparam logic [7:0] SC_PGDN      = 8'h51;

  localparam logic [7:0] CODE_UP     = 8'h80;
  localparam logic [7:0] CODE_DOWN   = 8'h81;
  localparam logic [7:0] CODE_LEFT   = 8'h82;
  localparam logic [7:0] CODE_RIGHT  = 8'h83;
  localparam logic [7:0] CODE_CTRL_C = 8'h03;
  localparam logic [7:0] CODE_CTRL_D = 8'h04;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef struct packed {
    logic ext;
    logic ctrl;
    logic shift;
    logic alt;
    logic altgr;
    logic caps;
  } sctc_flags_t;

  typedef struct packed {
    logic              push;
    logic [7:0]        ch;
    logic              compose;
    logic [SLOT_W-1:0] slot;
    logic              up;
    logic              dn;
  } sctc_action_t;

endpackage

`default_nettype wire

// File: rtl/core/scancode_to_char_decoder.sv
// ----------------------------------------------------------------------------
// scancode_to_char_decoder
// Set-1 scancode decoder with loadable keymaps, compose table and char FIFO.
// ----------------------------------------------------------------------------
// Each request word is handled in steps: the keymaps are read at acceptance,
// the decode and the compose/FIFO reads run in the next cycle (ST_EVAL), and
// the FIFO write and result land in ST_FIN, where the next word is accepted
// once the output is free. The keymap and compose RAM reads are registered.
// After reset the compose table is swept to zero, all 2048 entries, before
// the first word is taken; configuration writes are taken at any time.
`default_nettype none

module scancode_to_char_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // scan_code[7:0], map_select[9:8], map_index[16:10], entry_value[24:17],
  // dead_slot[27:25], base_char[35:28], zero fill[39:36]
  input  wire logic [39:0] s_axis_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // char_out[7:0], char_valid[8], chars_waiting[16:9], overflow[17],
  // scroll_up_pulse[18], scroll_down_pulse[19], zero fill[23:20]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int unsigned AW  = sctc_pkg::FIFO_AW;
  localparam int unsigned CAW = sctc_pkg::CMP_AW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FIN
  } phase_e;

  phase_e               phase_q;
  logic [CAW:0]         clr_cnt_q;
  logic                 clr_busy;
  logic [7:0]           first_q, last_q;
  sctc_pkg::sctc_flags_t flags_q, flags_d;
  logic [7:0]           pending_q, pending_d;
  logic [AW-1:0]        wp_q, rp_q;
  logic [2:0]           req_q;
  logic [39:0]          item_q;
  sctc_pkg::sctc_action_t act_q, act_d;
  logic                 out_valid_q;
  logic [23:0]          out_data_q;

  logic                 accept, fin_go;
  logic [7:0]           nmap, smap, amap, cmp_rdata, fifo_rdata;

  logic [7:0]           it_sc, it_val, it_base;
  logic [1:0]           it_sel;
  logic [6:0]           it_idx;
  logic [2:0]           it_slot;

  assign it_sc   = item_q[7:0];
  assign it_sel  = item_q[9:8];
  assign it_idx  = item_q[16:10];
  assign it_val  = item_q[24:17];
  assign it_slot = item_q[27:25];
  assign it_base = item_q[35:28];

  assign clr_busy      = ~clr_cnt_q[CAW];
  assign fin_go        = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~clr_busy & ((phase_q == ST_IDLE) | ((phase_q == ST_FIN) & fin_go));
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  logic eval, km_we;
  assign eval  = (phase_q == ST_EVAL);
  assign km_we = eval & (req_q == sctc_pkg::REQ_KEYMAP);

  sctc_ram #(.DEPTH(sctc_pkg::MAP_DEPTH), .WIDTH(8)) u_nmap (
    .clk_i, .we_i(km_we & (it_sel == sctc_pkg::MAP_NORMAL)), .waddr_i(it_idx),
    .wdata_i(it_val), .re_i(accept), .raddr_i(s_axis_tdata[6:0]), .rdata_o(nmap)
  );
  sctc_ram #(.DEPTH(sctc_pkg::MAP_DEPTH), .WIDTH(8)) u_smap (
    .clk_i, .we_i(km_we & (it_sel == sctc_pkg::MAP_SHIFT)), .waddr_i(it_idx),
    .wdata_i(it_val), .re_i(accept), .raddr_i(s_axis_tdata[6:0]), .rdata_o(smap)
  );
  sctc_ram #(.DEPTH(sctc_pkg::MAP_DEPTH), .WIDTH(8)) u_amap (
    .clk_i, .we_i(km_we & (it_sel == sctc_pkg::MAP_ALTGR)), .waddr_i(it_idx),
    .wdata_i(it_val), .re_i(accept), .raddr_i(s_axis_tdata[6:0]), .rdata_o(amap)
  );

  // compose table: clearing sweep after reset, then request writes
  logic           cmp_we;
  logic [CAW-1:0] cmp_waddr, cmp_raddr;
  logic [7:0]     cmp_wdata;
  assign cmp_we    = clr_busy | (eval & (req_q == sctc_pkg::REQ_COMPOSE) &
                     ({1'b0, it_slot} < 4'(sctc_pkg::DEAD_KEY_SLOTS)));
  assign cmp_waddr = clr_busy ? clr_cnt_q[CAW-1:0]
                              : {it_slot[sctc_pkg::SLOT_W-1:0], it_base};
  assign cmp_wdata = clr_busy ? 8'd0 : it_val;
  assign cmp_raddr = {act_d.slot, act_d.ch};

  sctc_ram #(.DEPTH(sctc_pkg::CMP_DEPTH), .WIDTH(8)) u_cmp (
    .clk_i, .we_i(cmp_we), .waddr_i(cmp_waddr), .wdata_i(cmp_wdata),
    .re_i(eval), .raddr_i(cmp_raddr), .rdata_o(cmp_rdata)
  );

  sctc_decode u_dec (
    .sc_i(it_sc), .flags_i(flags_q), .pending_i(pending_q), .first_i(first_q),
    .last_i(last_q), .nmap_i(nmap), .smap_i(smap), .amap_i(amap),
    .flags_o(flags_d), .pending_o(pending_d), .act_o(act_d)
  );

  // finish stage: compose substitution, case fold, FIFO push, pop and clear
  logic [7:0]    ch_cmp, ch_fin;
  logic          do_push, full, do_write, do_pop;
  logic [AW-1:0] wp_d, rp_d, cnt;
  logic [AW:0]   cnt_w;
  logic [7:0]    waiting;

  always_comb begin
    ch_cmp = (act_q.compose && cmp_rdata != 8'd0) ? cmp_rdata : act_q.ch;
    ch_fin = ch_cmp;
    if (ch_cmp >= sctc_pkg::CH_LOWER_A && ch_cmp <= sctc_pkg::CH_LOWER_Z) begin
      if (flags_q.caps != flags_q.shift) ch_fin = ch_cmp - sctc_pkg::CASE_DELTA;
    end else if (ch_cmp >= sctc_pkg::CH_UPPER_A && ch_cmp <= sctc_pkg::CH_UPPER_Z) begin
      if (flags_q.caps) ch_fin = ch_cmp + sctc_pkg::CASE_DELTA;
    end
    do_push  = (req_q == sctc_pkg::REQ_SCAN) & act_q.push;
    full     = (wp_q + 1'b1) == rp_q;
    do_write = do_push & ~full;
    do_pop   = (req_q == sctc_pkg::REQ_POP) & (wp_q != rp_q);
    wp_d     = wp_q;
    rp_d     = rp_q;
    if (req_q == sctc_pkg::REQ_CLEAR) begin
      wp_d = '0;
      rp_d = '0;
    end else begin
      if (do_write) wp_d = wp_q + 1'b1;
      if (do_pop)   rp_d = rp_q + 1'b1;
    end
    cnt     = wp_d - rp_d;
    cnt_w   = {1'b0, cnt};
    waiting = (cnt_w > (AW + 1)'(255)) ? 8'hFF : cnt_w[7:0];
  end

  sctc_ram #(.DEPTH(sctc_pkg::FIFO_DEPTH), .WIDTH(8)) u_fifo (
    .clk_i, .we_i((phase_q == ST_FIN) & fin_go & do_write), .waddr_i(wp_q),
    .wdata_i(ch_fin), .re_i(eval), .raddr_i(rp_q), .rdata_o(fifo_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ST_IDLE;
      clr_cnt_q   <= '0;
      first_q     <= 8'd144;
      last_q      <= 8'd151;
      flags_q     <= '0;
      pending_q   <= 8'd0;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      req_q       <= sctc_pkg::REQ_SCAN;
      item_q      <= '0;
      act_q       <= '0;
    end else begin
      if (clr_busy) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sctc_pkg::CFG_DEAD_FIRST: first_q <= cfg_wdata_i;
          sctc_pkg::CFG_DEAD_LAST:  last_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tready && !((phase_q == ST_FIN) && fin_go)) out_valid_q <= 1'b0;
      case (phase_q)
        ST_IDLE: begin
          if (accept) phase_q <= ST_EVAL;
        end
        ST_EVAL: begin
          act_q <= act_d;
          if (req_q == sctc_pkg::REQ_SCAN) begin
            flags_q   <= flags_d;
            pending_q <= pending_d;
          end else if (req_q == sctc_pkg::REQ_KEYMAP && it_sel != 2'd3) begin
            pending_q <= 8'd0;
          end
          phase_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            wp_q        <= wp_d;
            rp_q        <= rp_d;
            out_valid_q <= 1'b1;
            out_data_q  <= {4'd0,
                            (req_q == sctc_pkg::REQ_SCAN) & act_q.dn,
                            (req_q == sctc_pkg::REQ_SCAN) & act_q.up,
                            do_push & full,
                            waiting,
                            do_pop,
                            do_pop ? fifo_rdata : 8'd0};
            phase_q     <= accept ? ST_EVAL : ST_IDLE;
          end
        end
        default: phase_q <= ST_IDLE;
      endcase
      if (accept) begin
        req_q  <= s_axis_tuser;
        item_q <= s_axis_tdata;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sctc_ram.sv
// ----------------------------------------------------------------------------
// sctc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sctc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sctc_decode.sv
// ----------------------------------------------------------------------------
// sctc_decode
// Scancode byte decode: modifier flags, dead key and the character to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sctc_decode (
  input  wire logic [7:0]          sc_i,
  input  wire sctc_pkg::sctc_flags_t flags_i,
  input  wire logic [7:0]          pending_i,
  input  wire logic [7:0]          first_i,
  input  wire logic [7:0]          last_i,
  input  wire logic [7:0]          nmap_i,
  input  wire logic [7:0]          smap_i,
  input  wire logic [7:0]          amap_i,
  output sctc_pkg::sctc_flags_t    flags_o,
  output logic [7:0]               pending_o,
  output sctc_pkg::sctc_action_t   act_o
);

  logic [7:0] c;
  logic [7:0] rel;
  logic [7:0] diff;
  logic       dead_ok;
  logic       is_key;

  always_comb begin
    if (flags_i.altgr && (amap_i != 8'd0)) begin
      c = amap_i;
    end else if (flags_i.shift) begin
      c = smap_i;
    end else begin
      c = nmap_i;
    end
    rel     = {1'b0, sc_i[6:0]};
    diff    = pending_i - first_i;
    dead_ok = (pending_i >= first_i) && ({1'b0, diff} < 9'(sctc_pkg::DEAD_KEY_SLOTS));
  end

  always_comb begin
    flags_o   = flags_i;
    pending_o = pending_i;
    act_o     = '0;
    is_key    = 1'b0;
    if (sc_i == sctc_pkg::SC_PREFIX_E0) begin
      flags_o.ext = 1'b1;
    end else if (sc_i[7]) begin
      if (flags_i.ext) begin
        if (rel == sctc_pkg::SC_ALT) flags_o.altgr = 1'b0;
        flags_o.ext = 1'b0;
      end else if (rel == sctc_pkg::SC_CTRL) begin
        flags_o.ctrl = 1'b0;
      end else if (rel == sctc_pkg::SC_LSHIFT || rel == sctc_pkg::SC_RSHIFT) begin
        flags_o.shift = 1'b0;
      end else if (rel == sctc_pkg::SC_ALT) begin
        flags_o.alt = 1'b0;
      end
    end else begin
      is_key = 1'b1;
      if (flags_i.ext) begin
        flags_o.ext = 1'b0;
        if (sc_i == sctc_pkg::SC_ALT) begin
          flags_o.altgr = 1'b1;
          is_key        = 1'b0;
        end
      end
    end

    if (is_key) begin
      case (sc_i)
        sctc_pkg::SC_CTRL:   flags_o.ctrl  = 1'b1;
        sctc_pkg::SC_LSHIFT,
        sctc_pkg::SC_RSHIFT: flags_o.shift = 1'b1;
        sctc_pkg::SC_ALT:    flags_o.alt   = 1'b1;
        sctc_pkg::SC_CAPS:   flags_o.caps  = ~flags_i.caps;
        sctc_pkg::SC_UP: begin
          act_o.push = 1'b1;
          act_o.ch   = sctc_pkg::CODE_UP;
        end
        sctc_pkg::SC_DOWN: begin
          act_o.push = 1'b1;
          act_o.ch   = sctc_pkg::CODE_DOWN;
        end
        sctc_pkg::SC_LEFT: begin
          act_o.push = 1'b1;
          act_o.ch   = sctc_pkg::CODE_LEFT;
        end
        sctc_pkg::SC_RIGHT: begin
          act_o.push = 1'b1;
          act_o.ch   = sctc_pkg::CODE_RIGHT;
        end
        sctc_pkg::SC_PGUP: act_o.up = 1'b1;
        sctc_pkg::SC_PGDN: act_o.dn = 1'b1;
        default: begin
          if (c != 8'd0) begin
            if (c >= first_i && c <= last_i) begin
              pending_o = c;
            end else if (flags_i.ctrl &&
                         (c == sctc_pkg::CH_LOWER_C || c == sctc_pkg::CH_UPPER_C)) begin
              act_o.push = 1'b1;
              act_o.ch   = sctc_pkg::CODE_CTRL_C;
            end else if (flags_i.ctrl &&
                         (c == sctc_pkg::CH_LOWER_D || c == sctc_pkg::CH_UPPER_D)) begin
              act_o.push = 1'b1;
              act_o.ch   = sctc_pkg::CODE_CTRL_D;
            end else begin
              act_o.push = 1'b1;
              act_o.ch   = c;
              if (pending_i != 8'd0) begin
                act_o.compose = dead_ok;
                act_o.slot    = diff[sctc_pkg::SLOT_W-1:0];
                pending_o     = 8'd0;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire
